FILE: sv/eiot_pkg.sv
`timescale 1ns / 1ps
// Package for the encoder index offset tracker.
// Holds the widths, pulse thresholds, register indexes and sequencer states.
package eiot_pkg;

    localparam int COUNT_WIDTH = 16;
    // Low COUNT_WIDTH bits of the 16-bit sampled counter are used.
    localparam logic [15:0] CNT_MASK = 16'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [2:0] PULSE_SAT   = 3'd5;
    localparam logic [2:0] PULSE_LEARN = 3'd3;

    // Magnitude of count + offset fits in 17 bits; one dividend bit per step.
    localparam int MAG_W     = 17;
    localparam int STEP_CW   = $clog2(MAG_W + 1);

    localparam logic [15:0] CPR_RESET = 16'd4096;
    localparam logic [15:0] MID_RESET = 16'd2048;
    localparam logic [15:0] TOL_RESET = 16'd64;

    localparam logic [1:0] REG_CPR = 2'd0;
    localparam logic [1:0] REG_MID = 2'd1;
    localparam logic [1:0] REG_TOL = 2'd2;

    localparam logic [1:0] ADJ_ZERO = 2'b00;
    localparam logic [1:0] ADJ_UP   = 2'b01;
    localparam logic [1:0] ADJ_DOWN = 2'b11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MAG,
        ST_DIV,
        ST_FIX,
        ST_DEV,
        ST_DEV_NEG,
        ST_OUT
    } state_t;

endpackage

FILE: sv/encoder_index_offset_tracker_top.sv
`timescale 1ns / 1ps
// Encoder index offset tracker: gate-closed, counting and learning pulses go from ST_DECODE
// straight to ST_OUT; tracking pulses pass ST_MAG, the bit-serial remainder loop ST_DIV, ST_FIX,
// ST_DEV and, only when index_position lies above mid_position, ST_DEV_NEG before ST_OUT.
// One transaction at a time: s_tready is high only while the sequencer is idle; a result
// waiting in the output register does not block the next input transaction.
// A new transaction is accepted only after ST_OUT has written the previous one to the output register.
// aresetn (synchronous, active low) clears pulse count, offset, target and loss flag and
// restores counts_per_rev 4096, mid_position 2048, tolerance 64.
// Depends on eiot_pkg.
module encoder_index_offset_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] encoder_count
    input  logic [1:0]  s_tuser,   // [0] encoder_ready, [1] hall_learned
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] count_adjust, [17:2] index_position, [33:18] deviation,
    // [34] error_now, [35] error_latched, [39:36] zero
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    eiot_pkg::state_t state_reg, state_next;

    logic [15:0] cpr_reg, mid_reg, tol_reg;
    logic [2:0]  pulse_count_reg, pulse_count_next;
    logic [17:0] offset_reg, offset_next;
    logic [16:0] target_reg, target_next;
    logic        loss_flag_reg, loss_flag_next;

    logic [15:0] count_reg, count_next;
    logic        gate_reg, gate_next;
    logic [17:0] sum_reg, sum_next;
    logic [16:0] mag_reg, mag_next;
    logic [15:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [eiot_pkg::STEP_CW-1:0] step_reg, step_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] dev_reg, dev_next;
    logic        track_reg, track_next;
    logic        lerr_reg, lerr_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    // shared add/subtract unit
    logic [17:0] unit_a, unit_b;
    logic        unit_sub;
    logic [18:0] unit_res;
    logic        unit_borrow;

    logic [15:0] cpr_eff;
    logic [16:0] rem_shift;
    logic [2:0]  pulse_inc;
    logic        err_now;
    logic [1:0]  adjust;

    assign unit_res    = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                         + {18'd0, unit_sub};
    assign unit_borrow = unit_sub & ~unit_res[18];

    assign cpr_eff   = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;
    assign rem_shift = {rem_reg, mag_reg[eiot_pkg::MAG_W-1]};
    assign pulse_inc = (pulse_count_reg >= eiot_pkg::PULSE_SAT) ? eiot_pkg::PULSE_SAT
                                                                 : pulse_count_reg + 3'd1;

    assign s_tready = aresetn && (state_reg == eiot_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg <= eiot_pkg::CPR_RESET;
            mid_reg <= eiot_pkg::MID_RESET;
            tol_reg <= eiot_pkg::TOL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                eiot_pkg::REG_CPR: cpr_reg <= cfg_data;
                eiot_pkg::REG_MID: mid_reg <= cfg_data;
                eiot_pkg::REG_TOL: tol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= eiot_pkg::ST_IDLE;
            pulse_count_reg <= 3'd0;
            offset_reg      <= 18'd0;
            target_reg      <= 17'd0;
            loss_flag_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            step_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            pulse_count_reg <= pulse_count_next;
            offset_reg      <= offset_next;
            target_reg      <= target_next;
            loss_flag_reg   <= loss_flag_next;
            m_tvalid_reg    <= m_tvalid_next;
            step_reg        <= step_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        gate_reg    <= gate_next;
        sum_reg     <= sum_next;
        mag_reg     <= mag_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        idx_reg     <= idx_next;
        dev_reg     <= dev_next;
        track_reg   <= track_next;
        lerr_reg    <= lerr_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next       = state_reg;
        pulse_count_next = pulse_count_reg;
        offset_next      = offset_reg;
        target_next      = target_reg;
        loss_flag_next   = loss_flag_reg;
        count_next       = count_reg;
        gate_next        = gate_reg;
        sum_next         = sum_reg;
        mag_next         = mag_reg;
        rem_next         = rem_reg;
        neg_next         = neg_reg;
        step_next        = step_reg;
        idx_next         = idx_reg;
        dev_next         = dev_reg;
        track_next       = track_reg;
        lerr_next        = lerr_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        unit_a           = 18'd0;
        unit_b           = 18'd0;
        unit_sub         = 1'b1;
        err_now          = 1'b0;
        adjust           = eiot_pkg::ADJ_ZERO;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            eiot_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    count_next = s_tdata & eiot_pkg::CNT_MASK;
                    gate_next  = s_tuser[0] & s_tuser[1];
                    state_next = eiot_pkg::ST_DECODE;
                end
            end
            eiot_pkg::ST_DECODE: begin
                track_next = 1'b0;
                lerr_next  = 1'b0;
                idx_next   = 16'd0;
                dev_next   = 16'd0;
                state_next = eiot_pkg::ST_OUT;
                if (gate_reg) begin
                    pulse_count_next = pulse_inc;
                    if (pulse_inc >= eiot_pkg::PULSE_SAT) begin
                        // count + offset
                        unit_a     = {2'd0, count_reg};
                        unit_b     = offset_reg;
                        unit_sub   = 1'b0;
                        sum_next   = unit_res[17:0];
                        track_next = 1'b1;
                        state_next = eiot_pkg::ST_MAG;
                    end else if (pulse_inc >= eiot_pkg::PULSE_LEARN) begin
                        unit_a      = {2'd0, mid_reg};
                        unit_b      = {2'd0, count_reg};
                        offset_next = unit_res[17:0];
                        target_next = {1'b0, count_reg};
                        // offset outside +-mid reduces to count > 2*mid
                        lerr_next   = {1'b0, count_reg} > {mid_reg, 1'b0};
                    end
                end
            end
            eiot_pkg::ST_MAG: begin
                unit_a     = 18'd0;
                unit_b     = sum_reg;
                neg_next   = sum_reg[17];
                mag_next   = sum_reg[17] ? unit_res[16:0] : sum_reg[16:0];
                rem_next   = 16'd0;
                step_next  = eiot_pkg::STEP_CW'(eiot_pkg::MAG_W - 1);
                state_next = eiot_pkg::ST_DIV;
            end
            eiot_pkg::ST_DIV: begin
                // restoring remainder step, one dividend bit per cycle
                unit_a   = {1'b0, rem_shift};
                unit_b   = {2'd0, cpr_eff};
                rem_next = unit_borrow ? rem_shift[15:0] : unit_res[15:0];
                mag_next = {mag_reg[eiot_pkg::MAG_W-2:0], 1'b0};
                if (step_reg == '0) begin
                    state_next = eiot_pkg::ST_FIX;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            eiot_pkg::ST_FIX: begin
                unit_a     = {2'd0, cpr_eff};
                unit_b     = {2'd0, rem_reg};
                idx_next   = (neg_reg && rem_reg != 16'd0) ? unit_res[15:0] : rem_reg;
                state_next = eiot_pkg::ST_DEV;
            end
            eiot_pkg::ST_DEV: begin
                unit_a   = {2'd0, mid_reg};
                unit_b   = {2'd0, idx_reg};
                dev_next = unit_res[15:0];
                state_next = unit_borrow ? eiot_pkg::ST_DEV_NEG : eiot_pkg::ST_OUT;
            end
            eiot_pkg::ST_DEV_NEG: begin
                unit_a     = {2'd0, idx_reg};
                unit_b     = {2'd0, mid_reg};
                dev_next   = unit_res[15:0];
                state_next = eiot_pkg::ST_OUT;
            end
            eiot_pkg::ST_OUT: begin
                err_now = lerr_reg | (track_reg & (dev_reg >= tol_reg));
                if (track_reg && !err_now) begin
                    if ({1'b0, count_reg} < target_reg) begin
                        adjust = eiot_pkg::ADJ_UP;
                    end else if ({1'b0, count_reg} > target_reg) begin
                        adjust = eiot_pkg::ADJ_DOWN;
                    end
                end
                if (!m_tvalid_reg || m_tready) begin
                    loss_flag_next = loss_flag_reg | err_now;
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = {4'd0, loss_flag_reg | err_now, err_now,
                                      dev_reg, idx_reg, adjust};
                    state_next     = eiot_pkg::ST_IDLE;
                end
            end
            default: state_next = eiot_pkg::ST_IDLE;
        endcase
    end

    // the sticky loss flag only clears through reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        loss_flag_reg |=> loss_flag_reg)
        else $error("loss flag cleared without reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_count_reg <= eiot_pkg::PULSE_SAT)
        else $error("pulse count above saturation");

    // remainder stays reduced during the bit-serial loop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eiot_pkg::ST_DIV || state_reg == eiot_pkg::ST_FIX)
        |-> (rem_reg < cpr_eff))
        else $error("remainder not below counts_per_rev");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34]) |-> m_tdata[35])
        else $error("error reported without latched flag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != eiot_pkg::ADJ_ZERO) |-> !m_tdata[34])
        else $error("correction issued on an error transaction");

endmodule
